FILE: rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, codes and defaults of the binary rectangle morphology unit.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_RADIUS_X = 15;
  localparam int DEF_MAX_RADIUS_Y = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int SIZE_REG_W = 11;
  localparam int RAD_REG_W  = 4;
  localparam int MODE_W     = 2;

  localparam logic [SIZE_REG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [SIZE_REG_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [RAD_REG_W-1:0]  RST_RADIUS_X     = 4'd1;
  localparam logic [RAD_REG_W-1:0]  RST_RADIUS_Y     = 4'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_OPEN   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_RADIUS_X     = 3'd2,
    REG_RADIUS_Y     = 3'd3,
    REG_OP_MODE      = 3'd4
  } reg_idx_e;

  // Per-item control of one filter stage. For the second stage hit is the
  // in-image gate that is combined with the first stage's value.
  typedef struct packed {
    logic step;
    logic fresh;
    logic hit;
    logic clr;
    logic inv;
  } stage_ctl_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic cascade;
  } out_ctl_t;

endpackage

FILE: rtl/bra_if.sv
// ----------------------------------------------------------------------------
// bra_in_if / bra_out_if
// Valid/ready channels of the morphology unit.
// ----------------------------------------------------------------------------
interface bra_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic drain;
  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface bra_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: rtl/bra_cell.sv
// ----------------------------------------------------------------------------
// bra_cell
// One tap of the row window: holds a hit bit and passes it to its neighbor.
// ----------------------------------------------------------------------------
module bra_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic shift,
  input  logic clr,
  input  logic d,
  input  logic mask,
  output logic q,
  output logic term
);

  logic q_r;
  logic q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = (FIRST || !clr) ? d : 1'b0;
    end else if (clr) begin
      q_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q    = q_r;
  assign term = q_nxt & mask;

endmodule

FILE: rtl/bra_stage.sv
// ----------------------------------------------------------------------------
// bra_stage
// One filter stage: column gap memory for the vertical extent and a chain
// of window cells for the horizontal extent.
// ----------------------------------------------------------------------------
module bra_stage #(
  parameter int MAX_WIDTH    = bra_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS_X = bra_pkg::DEF_MAX_RADIUS_X,
  parameter int MAX_RADIUS_Y = bra_pkg::DEF_MAX_RADIUS_Y,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int WIN = 2 * MAX_RADIUS_X + 1,
  localparam int RYW = $clog2(MAX_RADIUS_Y + 1),
  localparam int GW  = $clog2(2 * MAX_RADIUS_Y + 2)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                rd_en,
  input  logic [CW-1:0]       rd_col,
  input  bra_pkg::stage_ctl_t ctl,
  input  logic [CW-1:0]       col,
  input  logic [WIN-1:0]      mask,
  input  logic [RYW-1:0]      ry,
  output logic                val
);

  localparam logic [GW-1:0] GAP_SAT = GW'(2 * MAX_RADIUS_Y + 1);

  logic [GW-1:0]  mem [MAX_WIDTH];
  logic [GW-1:0]  rd_r;
  logic [GW-1:0]  base;
  logic [GW-1:0]  g_nxt;
  logic           hit_bit;
  logic           shift;
  logic           clr;
  logic [WIN-1:0] q;
  logic [WIN-1:0] term;

  assign base    = ctl.fresh ? GAP_SAT : rd_r;
  assign g_nxt   = ctl.hit ? '0 : ((base < GAP_SAT) ? base + 1'b1 : GAP_SAT);
  assign hit_bit = (g_nxt <= {ry, 1'b0});
  assign shift   = en & ctl.step;
  assign clr     = en & ctl.clr;

  // read-first memory; the item one step ahead forwards its new gap
  always_ff @(posedge clk) begin
    if (en && rd_en) begin
      rd_r <= (ctl.step && col == rd_col) ? g_nxt : mem[rd_col];
    end
    if (shift) begin
      mem[col] <= g_nxt;
    end
  end

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    bra_cell #(.FIRST(k == 0)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .shift(shift),
      .clr  (clr),
      .d    ((k == 0) ? hit_bit : q[(k == 0) ? 0 : k - 1]),
      .mask (mask[k]),
      .q    (q[k]),
      .term (term[k])
    );
  end

  assign val = (|term) ^ ctl.inv;

endmodule

FILE: rtl/bra_front.sv
// ----------------------------------------------------------------------------
// bra_front
// Configuration registers, raster positions, fill counters and the per-item
// decisions of both stages, all settled when an item is taken.
// ----------------------------------------------------------------------------
module bra_front #(
  parameter int MAX_WIDTH    = bra_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bra_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS_X = bra_pkg::DEF_MAX_RADIUS_X,
  parameter int MAX_RADIUS_Y = bra_pkg::DEF_MAX_RADIUS_Y,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int WIN = 2 * MAX_RADIUS_X + 1,
  localparam int RYW = $clog2(MAX_RADIUS_Y + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bra_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              acc,
  input  logic                              pixel,
  input  logic                              drain,
  output bra_pkg::stage_ctl_t               s1,
  output logic [CW-1:0]                     col1,
  output logic [WIN-1:0]                    mask1,
  output bra_pkg::stage_ctl_t               s2,
  output logic [CW-1:0]                     col2,
  output logic [WIN-1:0]                    mask2,
  output bra_pkg::out_ctl_t                 oc,
  output logic [RYW-1:0]                    ry_eff
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RXW = $clog2(MAX_RADIUS_X + 1);
  localparam int RW = $clog2(MAX_HEIGHT) + 2;
  localparam int FW = $clog2(MAX_RADIUS_Y * MAX_WIDTH + MAX_RADIUS_X + 1);
  localparam int OW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [bra_pkg::SIZE_REG_W-1:0] width_r, height_r;
  logic [bra_pkg::RAD_REG_W-1:0]  rx_r, ry_r;
  bra_pkg::mode_e                 mode_r;

  logic [CW-1:0] in_col1_r, ctr_col1_r, in_col2_r, ctr_col2_r;
  logic [RW-1:0] in_row1_r, ctr_row1_r, in_row2_r, ctr_row2_r;
  logic [FW-1:0] fill1_r, fill2_r;
  logic [OW-1:0] cnt_r;
  logic [WW-1:0] hw1_r, hw2_r;

  logic [CW-1:0] in_col1_c, ctr_col1_c, in_col2_c, ctr_col2_c;
  logic [RW-1:0] in_row1_c, ctr_row1_c, in_row2_c, ctr_row2_c;
  logic [FW-1:0] fill1_c, fill2_c;
  logic [OW-1:0] cnt_c;
  logic [WW-1:0] hw1_c, hw2_c;

  logic [CW-1:0] in_col1_nxt, ctr_col1_nxt, in_col2_nxt, ctr_col2_nxt;
  logic [RW-1:0] in_row1_nxt, ctr_row1_nxt, in_row2_nxt, ctr_row2_nxt;
  logic [FW-1:0] fill1_nxt, fill2_nxt;
  logic [OW-1:0] cnt_nxt;
  logic [WW-1:0] hw1_nxt, hw2_nxt;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RXW-1:0] rx_eff;
  logic [FW-1:0]  lag;
  logic [OW-1:0]  total;
  logic           inv1, inv2, cascade;
  logic           ignore, new_frame, step1, prod1, go2, prod2, prod, emit;
  logic [RW-1:0]  row;

  always_comb begin
    if (width_r == '0) w_eff = WW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (height_r == '0) h_eff = HW'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_r);
    rx_eff = (32'(rx_r) > 32'(MAX_RADIUS_X)) ? RXW'(MAX_RADIUS_X) : RXW'(rx_r);
    ry_eff = (32'(ry_r) > 32'(MAX_RADIUS_Y)) ? RYW'(MAX_RADIUS_Y) : RYW'(ry_r);
  end

  assign lag     = FW'(32'(ry_eff) * 32'(w_eff) + 32'(rx_eff));
  assign total   = OW'(32'(w_eff) * 32'(h_eff));
  assign inv1    = (mode_r == bra_pkg::MODE_ERODE) || (mode_r == bra_pkg::MODE_OPEN);
  assign inv2    = (mode_r == bra_pkg::MODE_CLOSE);
  assign cascade = (mode_r == bra_pkg::MODE_CLOSE) || (mode_r == bra_pkg::MODE_OPEN);

  assign ignore    = drain && ((32'(in_row1_r) < 32'(h_eff)) || (32'(cnt_r) >= 32'(total)));
  assign new_frame = !drain && (32'(in_row1_r) >= 32'(h_eff));
  assign step1     = acc && !ignore;

  // counters as seen by this item, after a frame restart
  assign in_col1_c  = new_frame ? '0 : in_col1_r;
  assign in_row1_c  = new_frame ? '0 : in_row1_r;
  assign ctr_col1_c = new_frame ? '0 : ctr_col1_r;
  assign ctr_row1_c = new_frame ? '0 : ctr_row1_r;
  assign fill1_c    = new_frame ? '0 : fill1_r;
  assign in_col2_c  = new_frame ? '0 : in_col2_r;
  assign in_row2_c  = new_frame ? '0 : in_row2_r;
  assign ctr_col2_c = new_frame ? '0 : ctr_col2_r;
  assign ctr_row2_c = new_frame ? '0 : ctr_row2_r;
  assign fill2_c    = new_frame ? '0 : fill2_r;
  assign cnt_c      = new_frame ? '0 : cnt_r;
  assign hw1_c      = new_frame ? '0 : hw1_r;
  assign hw2_c      = new_frame ? '0 : hw2_r;

  assign prod1 = (fill1_c >= lag);
  assign go2   = prod1 && cascade;
  assign prod2 = (fill2_c >= lag);
  assign prod  = cascade ? (go2 && prod2) : prod1;
  assign row   = cascade ? ctr_row2_c : ctr_row1_c;
  assign emit  = prod && (32'(row) < 32'(h_eff)) && (32'(cnt_c) < 32'(total));

  always_comb begin
    in_col1_nxt  = in_col1_c;
    in_row1_nxt  = in_row1_c;
    ctr_col1_nxt = ctr_col1_c;
    ctr_row1_nxt = ctr_row1_c;
    fill1_nxt    = fill1_c;
    in_col2_nxt  = in_col2_c;
    in_row2_nxt  = in_row2_c;
    ctr_col2_nxt = ctr_col2_c;
    ctr_row2_nxt = ctr_row2_c;
    fill2_nxt    = fill2_c;
    cnt_nxt      = cnt_c;
    hw1_nxt      = hw1_c;
    hw2_nxt      = hw2_c;
    // columns are written in order from zero, so a count marks the written ones
    if (32'(in_col1_c) >= 32'(hw1_c)) begin
      hw1_nxt = WW'(32'(in_col1_c) + 32'd1);
    end
    if (32'(in_col1_c) + 32'd1 >= 32'(w_eff)) begin
      in_col1_nxt = '0;
      in_row1_nxt = in_row1_c + 1'b1;
    end else begin
      in_col1_nxt = in_col1_c + 1'b1;
    end
    if (!prod1) begin
      fill1_nxt = fill1_c + 1'b1;
    end else if (32'(ctr_col1_c) + 32'd1 >= 32'(w_eff)) begin
      ctr_col1_nxt = '0;
      ctr_row1_nxt = ctr_row1_c + 1'b1;
    end else begin
      ctr_col1_nxt = ctr_col1_c + 1'b1;
    end
    if (go2) begin
      if (32'(in_col2_c) >= 32'(hw2_c)) begin
        hw2_nxt = WW'(32'(in_col2_c) + 32'd1);
      end
      if (32'(in_col2_c) + 32'd1 >= 32'(w_eff)) begin
        in_col2_nxt = '0;
        in_row2_nxt = in_row2_c + 1'b1;
      end else begin
        in_col2_nxt = in_col2_c + 1'b1;
      end
      if (!prod2) begin
        fill2_nxt = fill2_c + 1'b1;
      end else if (32'(ctr_col2_c) + 32'd1 >= 32'(w_eff)) begin
        ctr_col2_nxt = '0;
        ctr_row2_nxt = ctr_row2_c + 1'b1;
      end else begin
        ctr_col2_nxt = ctr_col2_c + 1'b1;
      end
    end
    if (emit) begin
      cnt_nxt = cnt_c + 1'b1;
    end
  end

  // window taps that land on in-image columns around the output column
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      mask1[k] = (k <= 2 * int'(rx_eff)) && (k <= int'(ctr_col1_c) + int'(rx_eff)) &&
                 (k + int'(w_eff) > int'(ctr_col1_c) + int'(rx_eff));
      mask2[k] = (k <= 2 * int'(rx_eff)) && (k <= int'(ctr_col2_c) + int'(rx_eff)) &&
                 (k + int'(w_eff) > int'(ctr_col2_c) + int'(rx_eff));
    end
  end

  always_comb begin
    s1.step  = step1;
    s1.fresh = (32'(in_col1_c) >= 32'(hw1_c));
    s1.hit   = !drain && (pixel != inv1);
    s1.clr   = new_frame;
    s1.inv   = inv1;
    s2.step  = go2;
    s2.fresh = (32'(in_col2_c) >= 32'(hw2_c));
    s2.hit   = (32'(ctr_row1_c) < 32'(h_eff));
    s2.clr   = new_frame;
    s2.inv   = inv2;
    oc.emit    = emit;
    oc.last    = (32'(cnt_c) + 32'd1 == 32'(total));
    oc.cascade = cascade;
  end

  assign col1 = in_col1_c;
  assign col2 = in_col2_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= bra_pkg::RST_IMAGE_WIDTH;
      height_r   <= bra_pkg::RST_IMAGE_HEIGHT;
      rx_r       <= bra_pkg::RST_RADIUS_X;
      ry_r       <= bra_pkg::RST_RADIUS_Y;
      mode_r     <= bra_pkg::MODE_ERODE;
      in_col1_r  <= '0;
      in_row1_r  <= '0;
      ctr_col1_r <= '0;
      ctr_row1_r <= '0;
      fill1_r    <= '0;
      in_col2_r  <= '0;
      in_row2_r  <= '0;
      ctr_col2_r <= '0;
      ctr_row2_r <= '0;
      fill2_r    <= '0;
      cnt_r      <= '0;
      hw1_r      <= '0;
      hw2_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          bra_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          bra_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
          bra_pkg::REG_RADIUS_X:     rx_r     <= cfg_data[bra_pkg::RAD_REG_W-1:0];
          bra_pkg::REG_RADIUS_Y:     ry_r     <= cfg_data[bra_pkg::RAD_REG_W-1:0];
          bra_pkg::REG_OP_MODE:      mode_r   <= bra_pkg::mode_e'(cfg_data[bra_pkg::MODE_W-1:0]);
          default: ;
        endcase
      end
      if (step1) begin
        in_col1_r  <= in_col1_nxt;
        in_row1_r  <= in_row1_nxt;
        ctr_col1_r <= ctr_col1_nxt;
        ctr_row1_r <= ctr_row1_nxt;
        fill1_r    <= fill1_nxt;
        in_col2_r  <= in_col2_nxt;
        in_row2_r  <= in_row2_nxt;
        ctr_col2_r <= ctr_col2_nxt;
        ctr_row2_r <= ctr_row2_nxt;
        fill2_r    <= fill2_nxt;
        cnt_r      <= cnt_nxt;
        hw1_r      <= hw1_nxt;
        hw2_r      <= hw2_nxt;
      end
    end
  end

endmodule

FILE: rtl/binary_rect_morphology_unit.sv
// ----------------------------------------------------------------------------
// binary_rect_morphology_unit
// Binary erode, dilate, close or open of a raster stream with a centered
// rectangle; window positions outside the image do not count.
// ----------------------------------------------------------------------------
// Takes one pixel or drain item per clock unless a result stalls, and
// gives at most one result per item via the p0, p1 and output registers; a
// held result frees the input in the same cycle it is taken. In raster
// terms each filter stage lags radius_y*image_width + radius_x items, twice
// that for close and open; drain items push the last results of a frame out.
// The per-column gap memories are read and written once per item, and a
// window cell chain per stage shifts one tap per item. A pixel after a full
// frame starts the next frame; a count of columns written since frame start
// marks the others as empty, so the stores restart without a clearing pass.
module binary_rect_morphology_unit #(
  parameter int MAX_WIDTH    = bra_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bra_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS_X = bra_pkg::DEF_MAX_RADIUS_X,
  parameter int MAX_RADIUS_Y = bra_pkg::DEF_MAX_RADIUS_Y
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
  bra_in_if.sink                         in_ch,
  bra_out_if.source                      out_ch
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WIN = 2 * MAX_RADIUS_X + 1;
  localparam int RYW = $clog2(MAX_RADIUS_Y + 1);

  logic                en;
  logic                acc;
  bra_pkg::stage_ctl_t f_s1, f_s2;
  logic [CW-1:0]       f_col1, f_col2;
  logic [WIN-1:0]      f_mask1, f_mask2;
  bra_pkg::out_ctl_t   f_oc;
  logic [RYW-1:0]      ry_eff;

  // item after the stage-1 read
  logic                p0_valid_r;
  bra_pkg::stage_ctl_t p0_s1_r, p0_s2_r;
  logic [CW-1:0]       p0_col1_r, p0_col2_r;
  logic [WIN-1:0]      p0_mask1_r, p0_mask2_r;
  bra_pkg::out_ctl_t   p0_oc_r;
  // item after stage 1
  logic                p1_valid_r;
  bra_pkg::stage_ctl_t p1_s2_r;
  logic [CW-1:0]       p1_col2_r;
  logic [WIN-1:0]      p1_mask2_r;
  bra_pkg::out_ctl_t   p1_oc_r;
  logic                v1_r;

  bra_pkg::stage_ctl_t st1_ctl, st2_ctl;
  logic                v1, v2;
  logic                out_valid_r, pix_out_r, last_out_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign acc          = in_ch.valid && en;

  bra_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_RADIUS_X(MAX_RADIUS_X),
    .MAX_RADIUS_Y(MAX_RADIUS_Y)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .acc     (acc),
    .pixel   (in_ch.pixel_in),
    .drain   (in_ch.drain),
    .s1      (f_s1),
    .col1    (f_col1),
    .mask1   (f_mask1),
    .s2      (f_s2),
    .col2    (f_col2),
    .mask2   (f_mask2),
    .oc      (f_oc),
    .ry_eff  (ry_eff)
  );

  always_comb begin
    st1_ctl      = p0_s1_r;
    st1_ctl.step = p0_valid_r;
    st1_ctl.clr  = p0_valid_r && p0_s1_r.clr;
    st2_ctl      = p1_s2_r;
    st2_ctl.step = p1_valid_r && p1_s2_r.step;
    st2_ctl.clr  = p1_valid_r && p1_s2_r.clr;
    st2_ctl.hit  = p1_s2_r.hit && (v1_r != p1_s2_r.inv);
  end

  bra_stage #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_RADIUS_X(MAX_RADIUS_X),
    .MAX_RADIUS_Y(MAX_RADIUS_Y)
  ) u_stage1 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .rd_en (acc && f_s1.step),
    .rd_col(f_col1),
    .ctl   (st1_ctl),
    .col   (p0_col1_r),
    .mask  (p0_mask1_r),
    .ry    (ry_eff),
    .val   (v1)
  );

  bra_stage #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_RADIUS_X(MAX_RADIUS_X),
    .MAX_RADIUS_Y(MAX_RADIUS_Y)
  ) u_stage2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .rd_en (p0_valid_r && p0_s2_r.step),
    .rd_col(p0_col2_r),
    .ctl   (st2_ctl),
    .col   (p1_col2_r),
    .mask  (p1_mask2_r),
    .ry    (ry_eff),
    .val   (v2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r  <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        p0_valid_r  <= acc && f_s1.step;
        p1_valid_r  <= p0_valid_r;
        out_valid_r <= p1_valid_r && p1_oc_r.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_s1_r    <= f_s1;
      p0_s2_r    <= f_s2;
      p0_col1_r  <= f_col1;
      p0_col2_r  <= f_col2;
      p0_mask1_r <= f_mask1;
      p0_mask2_r <= f_mask2;
      p0_oc_r    <= f_oc;
      p1_s2_r    <= p0_s2_r;
      p1_col2_r  <= p0_col2_r;
      p1_mask2_r <= p0_mask2_r;
      p1_oc_r    <= p0_oc_r;
      v1_r       <= v1;
      pix_out_r  <= p1_oc_r.cascade ? v2 : v1_r;
      last_out_r <= p1_oc_r.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_out  = pix_out_r;
  assign out_ch.frame_last = last_out_r;

endmodule

FILE: rtl/bra_checker.sv
// ----------------------------------------------------------------------------
// bra_props
// Port-level checks of the morphology unit, bound to the top level.
// ----------------------------------------------------------------------------
module bra_props (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pixel_out,
  input logic frame_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_last))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_rect_morphology_unit bra_props u_bra_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_out (out_ch.pixel_out),
  .frame_last(out_ch.frame_last)
);

FILE: verif/bra_checker.sv
// ----------------------------------------------------------------------------
// bra_checker
// Watches the config port and both channels of the morphology unit, predicts
// every filtered pixel from the accepted items and compares it in order.
// ----------------------------------------------------------------------------
module bra_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
  bra_in_if                              in_ch,
  bra_out_if                             out_ch,
  output int                             errors,
  output int                             pending
);

  localparam int GAP_SAT = 2 * bra_pkg::DEF_MAX_RADIUS_Y + 1;
  localparam int WIN_W   = 2 * bra_pkg::DEF_MAX_RADIUS_X + 1;
  localparam int MAX_W   = bra_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H   = bra_pkg::DEF_MAX_HEIGHT;

  typedef struct packed {
    logic pix;
    logic last;
  } filt_pix_t;

  filt_pix_t filt_q[$];

  int unsigned    img_w, img_h, rad_x, rad_y;
  bra_pkg::mode_e mode;

  int          col_gap[2][MAX_W];
  logic [WIN_W-1:0] row_win[2];
  int unsigned in_col[2], in_row[2], ctr_col[2], ctr_row[2], fill[2];
  int unsigned out_cnt;

  function automatic int unsigned eff_w();
    if (img_w < 1) return 1;
    return (img_w > MAX_W) ? MAX_W : img_w;
  endfunction

  function automatic int unsigned eff_h();
    if (img_h < 1) return 1;
    return (img_h > MAX_H) ? MAX_H : img_h;
  endfunction

  function automatic void new_frame();
    for (int s = 0; s < 2; s++) begin
      for (int c = 0; c < MAX_W; c++) col_gap[s][c] = GAP_SAT;
      row_win[s] = '0;
      in_col[s] = 0; in_row[s] = 0; ctr_col[s] = 0; ctr_row[s] = 0; fill[s] = 0;
    end
    out_cnt = 0;
  endfunction

  // one filter stage; returns 1 when a windowed value comes out
  function automatic bit stage_step(int s, bit hit, bit inv, output bit val,
                                    output int unsigned rrow);
    int unsigned w, c, g;
    int          col;
    bit          any;
    w   = eff_w();
    c   = (in_col[s] < MAX_W) ? in_col[s] : 0;
    any = 0;
    val = 0;
    rrow = 0;
    g = hit ? 0 : ((col_gap[s][c] < GAP_SAT) ? col_gap[s][c] + 1 : GAP_SAT);
    col_gap[s][c] = g;
    row_win[s] = {row_win[s][WIN_W-2:0], (g <= 2 * rad_y)};
    if (in_col[s] + 1 >= w) begin
      in_col[s] = 0;
      in_row[s]++;
    end else begin
      in_col[s]++;
    end
    if (fill[s] < rad_y * w + rad_x) begin
      fill[s]++;
      return 0;
    end
    for (int k = 0; k <= 2 * rad_x; k++) begin
      col = int'(ctr_col[s]) + int'(rad_x) - k;
      if (col >= 0 && col < int'(w) && row_win[s][k]) any = 1;
    end
    val  = any ^ inv;
    rrow = ctr_row[s];
    if (ctr_col[s] + 1 >= w) begin
      ctr_col[s] = 0;
      ctr_row[s]++;
    end else begin
      ctr_col[s]++;
    end
    return 1;
  endfunction

  function automatic void predict_item(bit pix, bit drn);
    int unsigned h, total, r1, row;
    bit          inv1, inv2, hit, v1, val;
    h     = eff_h();
    total = eff_w() * h;
    inv1  = (mode == bra_pkg::MODE_ERODE) || (mode == bra_pkg::MODE_OPEN);
    inv2  = (mode == bra_pkg::MODE_CLOSE);
    if (drn) begin
      if (in_row[0] < h || out_cnt >= total) return;
      hit = 0;
    end else begin
      if (in_row[0] >= h) new_frame();
      hit = pix ^ inv1;
    end
    if (!stage_step(0, hit, inv1, v1, r1)) return;
    if (mode == bra_pkg::MODE_CLOSE || mode == bra_pkg::MODE_OPEN) begin
      if (!stage_step(1, (r1 < h) && (v1 ^ inv2), inv2, val, row)) return;
    end else begin
      val = v1;
      row = r1;
    end
    if (row >= h || out_cnt >= total) return;
    filt_q.push_back('{pix: val, last: (out_cnt + 1 == total)});
    out_cnt++;
  endfunction

  assign pending = filt_q.size();

  always @(posedge clk) begin
    filt_pix_t exp_pix;
    if (!rst_n) begin
      img_w  = bra_pkg::RST_IMAGE_WIDTH;
      img_h  = bra_pkg::RST_IMAGE_HEIGHT;
      rad_x  = bra_pkg::RST_RADIUS_X;
      rad_y  = bra_pkg::RST_RADIUS_Y;
      mode   = bra_pkg::MODE_ERODE;
      errors = 0;
      filt_q.delete();
      new_frame();
    end else begin
      if (cfg_we) begin
        case (bra_pkg::reg_idx_e'(cfg_idx))
          bra_pkg::REG_IMAGE_WIDTH:  img_w = cfg_data;
          bra_pkg::REG_IMAGE_HEIGHT: img_h = cfg_data;
          bra_pkg::REG_RADIUS_X:     rad_x = cfg_data[bra_pkg::RAD_REG_W-1:0];
          bra_pkg::REG_RADIUS_Y:     rad_y = cfg_data[bra_pkg::RAD_REG_W-1:0];
          bra_pkg::REG_OP_MODE:      mode = bra_pkg::mode_e'(cfg_data[bra_pkg::MODE_W-1:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (filt_q.size() == 0) begin
          $display("%0t: unexpected result pix=%b last=%b", $time,
                   out_ch.pixel_out, out_ch.frame_last);
          errors++;
        end else begin
          exp_pix = filt_q.pop_front();
          if (out_ch.pixel_out !== exp_pix.pix) begin
            $display("%0t: pixel_out expected %b actual %b", $time,
                     exp_pix.pix, out_ch.pixel_out);
            errors++;
          end
          if (out_ch.frame_last !== exp_pix.last) begin
            $display("%0t: frame_last expected %b actual %b", $time,
                     exp_pix.last, out_ch.frame_last);
            errors++;
          end
        end
      end
      // predict after the compare: a result never comes in its item's cycle
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.pixel_in, in_ch.drain);
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the binary rectangle morphology unit.
// ----------------------------------------------------------------------------
// Runs whole frames through every mode, directed corner sizes first, then
// random small frames, with random gaps and stalls on both channels. The
// checker predicts each result and counts mismatches.
module tb_top;

  localparam int MAX_W = bra_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H = bra_pkg::DEF_MAX_HEIGHT;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             errors;
  int                             pending;
  int                             items_sent;
  bit                             fast_send;

  bra_in_if  in_ch ();
  bra_out_if out_ch ();

  binary_rect_morphology_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  bra_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin
    int  taken;
    int  stall;
    bit  calm;
    taken = 0;
    calm  = 0;
    out_ch.ready = 0;
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 15);
      if (taken == 40) stall = 400;
      repeat (stall) @(negedge clk) out_ch.ready <= 0;
      @(negedge clk) out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

  task automatic send_item(bit pix, bit drn);
    int gap;
    gap = fast_send ? 0 : $urandom_range(0, 15);
    repeat (gap) @(negedge clk) in_ch.valid <= 0;
    @(negedge clk);
    in_ch.valid    <= 1;
    in_ch.pixel_in <= pix;
    in_ch.drain    <= drn;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk) in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bra_pkg::reg_idx_e idx, int unsigned val);
    @(negedge clk);
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= val[bra_pkg::CFG_DATA_W-1:0];
    @(negedge clk) cfg_we <= 0;
  endtask

  // density: percent of foreground; full_drain 0 cuts the first pass short
  // and sends the frame again, which drops the undrained results
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned rx,
                           int unsigned ry, bra_pkg::mode_e m, int density,
                           bit full_drain);
    int unsigned ew, eh, ndrain;
    int          passes;
    wait_idle();
    write_reg(bra_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bra_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(bra_pkg::REG_RADIUS_X, rx);
    write_reg(bra_pkg::REG_RADIUS_Y, ry);
    write_reg(bra_pkg::REG_OP_MODE, m);
    ew = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
    eh = (h < 1) ? 1 : ((h > MAX_H) ? MAX_H : h);
    passes = full_drain ? 1 : 2;
    for (int p = 0; p < passes; p++) begin
      for (int unsigned i = 0; i < ew * eh; i++) begin
        // stray drain inside the frame is ignored
        if ($urandom_range(0, 30) == 0) send_item(1'($urandom_range(0, 1)), 1);
        send_item($urandom_range(0, 99) < density, 0);
      end
      ndrain = 2 * (ry * ew + rx) + 3;
      if (p == 0 && !full_drain) ndrain = $urandom_range(0, ndrain / 2);
      for (int unsigned i = 0; i < ndrain; i++) send_item(1'($urandom_range(0, 1)), 1);
    end
    // sender holds until every result of the frame has come
    wait_idle();
  endtask

  initial begin
    rst_n          = 0;
    cfg_we         = 0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_ch.valid    = 0;
    in_ch.pixel_in = 0;
    in_ch.drain    = 0;
    items_sent     = 0;
    fast_send      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    send_item(1, 1);  // drain before any pixel
    run_frame(1, 1, 0, 0, bra_pkg::MODE_ERODE, 100, 1);
    run_frame(1, 1, 15, 15, bra_pkg::MODE_DILATE, 0, 1);
    run_frame(4, 3, 1, 1, bra_pkg::MODE_ERODE, 100, 1);
    run_frame(4, 3, 1, 1, bra_pkg::MODE_DILATE, 0, 1);
    run_frame(5, 4, 2, 1, bra_pkg::MODE_CLOSE, 50, 1);
    run_frame(6, 5, 1, 2, bra_pkg::MODE_OPEN, 50, 1);
    run_frame(7, 6, 3, 3, bra_pkg::MODE_OPEN, 70, 0);
    run_frame(7, 6, 3, 3, bra_pkg::MODE_CLOSE, 30, 1);
    fast_send = 1;
    run_frame(2047, 1, 15, 0, bra_pkg::MODE_ERODE, 90, 1);
    run_frame(0, 0, 2, 1, bra_pkg::MODE_DILATE, 10, 1);

    while (items_sent < 2000) begin
      fast_send = ($urandom_range(0, 3) == 0);
      run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 15),
                $urandom_range(0, 15), bra_pkg::mode_e'($urandom_range(0, 3)),
                $urandom_range(0, 100), $urandom_range(0, 9) != 0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
